/* hw/rtl/pls_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg
// Shared constants, operation and status codes, and control structs for the
// positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

    // list capacity
    localparam int DEPTH = 16;

    // item field widths
    localparam int FUNC_W   = 3;
    localparam int ITEM_W   = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // internal widths derived from the capacity
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_END   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_POS   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_END   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DEL_POS   = 3'd5;
    localparam logic [FUNC_W-1:0] FN_DUMP_FWD  = 3'd6;
    localparam logic [FUNC_W-1:0] FN_DUMP_REV  = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic exec;     // accepted item is executed this cycle
        logic step;     // next dump item is loaded this cycle
    } pls_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic exec_more;    // accepted item is a dump with further items
        logic step_more;    // dump has further items after this step
    } pls_stat_t;

endpackage

/* hw/rtl/pls_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_req_if
// Request channel: operation code, item to insert and position.
// ----------------------------------------------------------------------------
interface pls_req_if;
    import pls_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [ITEM_W-1:0] item;
    logic [POS_W-1:0]         pos;

    modport source (output valid, func, item, pos, input ready);
    modport sink   (input valid, func, item, pos, output ready);
endinterface

/* hw/rtl/pls_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_rsp_if
// Response channel: status, returned item, item count and last flag.
// ----------------------------------------------------------------------------
interface pls_rsp_if;
    import pls_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [ITEM_W-1:0] value;
    logic [COUNT_W-1:0]       count;
    logic                     last;

    modport source (output valid, status, value, count, last, input ready);
    modport sink   (input valid, status, value, count, last, output ready);
endinterface

/* hw/rtl/pls_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_ctrl
// Sequencer: accepts requests, steps multi-item dumps and owns the response
// valid flag.
// ----------------------------------------------------------------------------
module pls_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output pls_pkg::pls_cmd_t  cmd,
    input  pls_pkg::pls_stat_t stat
);
    import pls_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic state_reg;
    logic state_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic slot_free;

    // response register is free or is being emptied this cycle
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        req_ready  = 1'b0;
        cmd.exec   = 1'b0;
        cmd.step   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = slot_free;
                cmd.exec  = req_valid && slot_free;
                if (cmd.exec && stat.exec_more)
                begin
                    state_next = S_DUMP;
                end
            end
            S_DUMP:
            begin
                cmd.step = slot_free;
                if (cmd.step && !stat.step_more)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.exec || cmd.step)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

/* hw/rtl/pls_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_datapath
// Row of shifting cells holding the list, item count, dump index and the
// registered response payload.
// ----------------------------------------------------------------------------
module pls_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [pls_pkg::FUNC_W-1:0]        func,
    input  logic signed [pls_pkg::ITEM_W-1:0] item,
    input  logic [pls_pkg::POS_W-1:0]         pos,
    input  pls_pkg::pls_cmd_t                 cmd,
    output pls_pkg::pls_stat_t                stat,
    output logic [pls_pkg::STATUS_W-1:0]      status,
    output logic signed [pls_pkg::ITEM_W-1:0] value,
    output logic [pls_pkg::COUNT_W-1:0]       count,
    output logic                              last
);
    import pls_pkg::*;

    logic signed [ITEM_W-1:0] entries_reg [DEPTH];
    logic signed [ITEM_W-1:0] entries_next [DEPTH];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] dump_cnt_reg;
    logic [CNT_W-1:0] dump_cnt_next;
    logic             dump_rev_reg;
    logic             dump_rev_next;

    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic signed [ITEM_W-1:0] value_reg;
    logic signed [ITEM_W-1:0] value_next;
    logic                     last_reg;
    logic                     last_next;

    logic             is_ins;
    logic             is_del;
    logic             is_dump;
    logic             rev;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] tgt;
    logic [STATUS_W-1:0] op_status;
    logic             ins_ok;
    logic             del_ok;
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] seq_idx;
    logic [IDX_W-1:0] rd_idx;
    logic signed [ITEM_W-1:0] rd_data;

    // ---- decode --------------------------------------------------------
    assign count_ext = CMP_W'(count_reg);
    assign is_ins    = (func == FN_INS_FRONT) || (func == FN_INS_END) || (func == FN_INS_POS);
    assign is_del    = (func == FN_DEL_FRONT) || (func == FN_DEL_END) || (func == FN_DEL_POS);
    assign is_dump   = (func == FN_DUMP_FWD) || (func == FN_DUMP_REV);

    always_comb
    begin
        unique case (func)
            FN_INS_FRONT: tgt = '0;
            FN_INS_END:   tgt = count_ext;
            FN_INS_POS:   tgt = CMP_W'(pos);
            FN_DEL_FRONT: tgt = '0;
            FN_DEL_END:   tgt = count_ext - CMP_W'(1);
            FN_DEL_POS:   tgt = CMP_W'(pos);
            default:      tgt = '0;
        endcase
    end

    always_comb
    begin
        priority if (is_ins)
        begin
            if (count_reg == CNT_W'(DEPTH))
                op_status = ST_FULL;
            else if (tgt > count_ext)
                op_status = ST_BADPOS;
            else
                op_status = ST_OK;
        end
        else if (is_del)
        begin
            if (count_reg == '0)
                op_status = ST_EMPTY;
            else if (tgt >= count_ext)
                op_status = ST_BADPOS;
            else
                op_status = ST_OK;
        end
        else
        begin
            op_status = (count_reg == '0) ? ST_EMPTY : ST_OK;
        end
    end

    assign ins_ok = cmd.exec && is_ins && (op_status == ST_OK);
    assign del_ok = cmd.exec && is_del && (op_status == ST_OK);

    // ---- single read port: deleted item or dumped item -----------------
    assign rev     = cmd.exec ? (func == FN_DUMP_REV) : dump_rev_reg;
    assign base    = cmd.exec ? '0 : dump_cnt_reg;
    assign seq_idx = rev ? (count_reg - CNT_W'(1) - base) : base;
    assign rd_idx  = (cmd.exec && is_del) ? tgt[IDX_W-1:0] : seq_idx[IDX_W-1:0];
    assign rd_data = entries_reg[rd_idx];

    // ---- shifting cells ------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        localparam logic [CMP_W-1:0] G = CMP_W'(g);
        logic signed [ITEM_W-1:0] prev_item;
        logic signed [ITEM_W-1:0] next_item;

        if (g == 0)
        begin : g_first
            assign prev_item = entries_reg[g];
        end
        else
        begin : g_mid_lo
            assign prev_item = entries_reg[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_final
            assign next_item = entries_reg[g];
        end
        else
        begin : g_mid_hi
            assign next_item = entries_reg[g+1];
        end

        always_comb
        begin
            priority if (ins_ok && (G == tgt))
                entries_next[g] = item;
            else if (ins_ok && (G > tgt))
                entries_next[g] = prev_item;
            else if (del_ok && (G >= tgt))
                entries_next[g] = next_item;
            else
                entries_next[g] = entries_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entries_reg[i] <= entries_next[i];
        end
    end

    // ---- count, dump sequencing and response payload -------------------
    always_comb
    begin
        count_next    = count_reg;
        dump_cnt_next = dump_cnt_reg;
        dump_rev_next = dump_rev_reg;
        status_next   = status_reg;
        value_next    = value_reg;
        last_next     = last_reg;
        stat.exec_more = is_dump && (count_reg > CNT_W'(1));
        stat.step_more = (dump_cnt_reg + CNT_W'(1)) < count_reg;

        if (cmd.exec)
        begin
            if (ins_ok)
                count_next = count_reg + CNT_W'(1);
            else if (del_ok)
                count_next = count_reg - CNT_W'(1);
            status_next   = op_status;
            value_next    = (del_ok || (is_dump && (op_status == ST_OK))) ? rd_data : '0;
            last_next     = !stat.exec_more;
            dump_cnt_next = CNT_W'(1);
            dump_rev_next = (func == FN_DUMP_REV);
        end
        else if (cmd.step)
        begin
            status_next   = ST_OK;
            value_next    = rd_data;
            last_next     = !stat.step_more;
            dump_cnt_next = dump_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            dump_cnt_reg <= '0;
            dump_rev_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            dump_cnt_reg <= dump_cnt_next;
            dump_rev_reg <= dump_rev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
    end

    // count field reports the count after the operation
    logic [CNT_W-1:0] rsp_count_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.exec || cmd.step)
        begin
            rsp_count_reg <= count_next;
        end
    end

    assign status = status_reg;
    assign value  = value_reg;
    assign count  = COUNT_W'(rsp_count_reg);
    assign last   = last_reg;

endmodule

/* hw/rtl/positional_list_store_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store_top
// Bounded ordered list of signed 32-bit items with positional insert/delete.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per item: insert front/end/at pos, delete
//   front/end/at pos, forward dump or reverse dump. rsp returns status,
//   value (removed or dumped item), count after the operation and last.
//   Inserts, deletes and dumps of an empty list give one response item;
//   a dump gives one response item per held entry, last set on the final.
// Timing: the response item is registered at the edge that accepts the
//   request and is valid in the next cycle. Insert and delete update the
//   list at the accepting edge through a row of shifting cells, so with
//   rsp ready a new request is taken every cycle. With rsp ready a dump
//   loads one item per cycle; the next request can be taken in the cycle
//   after the final dump item is loaded.
// Reset: rst_n clears the item count and control state; the list reads as
//   empty at once, no clearing pass.
// Stall: while rsp is held not ready with a response pending, the
//   response register holds its item, req stays not ready and a dump
//   pauses; no item is lost or repeated.
// On any error status the list contents and count are left unchanged.
// ----------------------------------------------------------------------------
module positional_list_store_top
(
    input  logic       clk,
    input  logic       rst_n,
    pls_req_if.sink    req,
    pls_rsp_if.source  rsp
);
    import pls_pkg::*;

    pls_cmd_t  cmd;
    pls_stat_t stat;

    pls_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    pls_datapath u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .func   (req.func),
        .item   (req.item),
        .pos    (req.pos),
        .cmd    (cmd),
        .stat   (stat),
        .status (rsp.status),
        .value  (rsp.value),
        .count  (rsp.count),
        .last   (rsp.last)
    );

endmodule
